// ===== hdl/pclrc_pkg.sv =====
`timescale 1ns / 1ps

package pclrc_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int AGE_BITS  = 16;
  localparam int USE_BITS  = 8;
  localparam int VIEW_LOG2 = 16;
  localparam int HASH_W    = 32;
  localparam int OFF_W     = 40;
  localparam int SLOT_W    = 4;
  localparam int LEN_W     = 17;
  localparam int PAGE_W    = 24;
  localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  localparam logic [OFF_W-1:0]    VIEW_BYTES = OFF_W'(64'd1 << VIEW_LOG2);
  localparam logic [AGE_BITS-1:0] AGE_MAX    = '1;
  localparam logic [USE_BITS-1:0] USE_MAX    = '1;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [USE_BITS-1:0] use_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_FILLED    = 3'd1,
    ST_EVICTED   = 3'd2,
    ST_ALL_BUSY  = 3'd3,
    ST_NO_VICTIM = 3'd4,
    ST_BAD_REQ   = 3'd5,
    ST_RELEASED  = 3'd6,
    ST_REL_UNDER = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    CMD_HIT  = 2'd0,
    CMD_FILL = 2'd1,
    CMD_REL  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic              action;
    logic [HASH_W-1:0] file_hash;
    logic [OFF_W-1:0]  byte_offset;
    logic [OFF_W-1:0]  file_size;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_index;
    logic [LEN_W-1:0]  byte_count;
    logic [PAGE_W-1:0] page_index;
    logic              all_busy;
  } rsp_t;

  // Token that walks down the cell row, one cell per cycle.
  typedef struct packed {
    logic              rel_op;
    logic [HASH_W-1:0] hash;
    logic [PAGE_W-1:0] page;
    logic [SLOT_W-1:0] rel;
    logic              hit_v;
    idx_t              hit_idx;
    logic [LEN_W-1:0]  hit_len;
    logic              empty_v;
    idx_t              empty_idx;
    logic              v1_v;
    idx_t              v1_idx;
    age_t              v1_age;
    logic              v2_v;
    idx_t              v2_idx;
    age_t              v2_age;
    logic              some_free;
    use_t              rel_uses;
    logic [LEN_W-1:0]  rel_len;
    logic [PAGE_W-1:0] rel_page;
  } probe_t;

  typedef struct packed {
    logic              v;
    cmd_e              op;
    idx_t              idx;
    logic [HASH_W-1:0] hash;
    logic [PAGE_W-1:0] page;
    logic [LEN_W-1:0]  len;
  } commit_t;

endpackage

// ===== hdl/pclrc_cell.sv =====
`timescale 1ns / 1ps

module pclrc_cell import pclrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  idx_t    cell_idx_i,
  input  logic    pv_i,
  input  probe_t  probe_i,
  input  commit_t cmd_i,
  output logic    pv_o,
  output probe_t  probe_o,
  output logic    busy_o
);

  logic              valid_q;
  logic [HASH_W-1:0] tag_q;
  logic [PAGE_W-1:0] page_q;
  logic [LEN_W-1:0]  len_q;
  age_t              age_q;
  use_t              uses_q;
  logic              pv_q;
  probe_t            probe_q, probe_d;

  logic match, rel_match, sel;
  age_t age_inc, age_seen;

  assign match     = valid_q && (tag_q == probe_i.hash) && (page_q == probe_i.page);
  assign rel_match = (CMP_W'(cell_idx_i) == CMP_W'(probe_i.rel));
  assign age_inc   = (age_q == AGE_MAX) ? age_q : age_q + age_t'(1);
  assign age_seen  = match ? age_q : age_inc;
  assign sel       = cmd_i.v && (cmd_i.idx == cell_idx_i);

  always_comb begin
    probe_d = probe_i;
    if (!probe_i.rel_op) begin
      if (match) begin
        probe_d.hit_v   = 1'b1;
        probe_d.hit_idx = cell_idx_i;
        probe_d.hit_len = len_q;
      end
      if (!valid_q && !probe_i.empty_v) begin
        probe_d.empty_v   = 1'b1;
        probe_d.empty_idx = cell_idx_i;
      end
      if (uses_q == '0) begin
        probe_d.some_free = 1'b1;
        // Strict compare keeps the first of several equally old entries.
        if ((tag_q != probe_i.hash) && (age_seen > probe_i.v1_age)) begin
          probe_d.v1_v   = 1'b1;
          probe_d.v1_idx = cell_idx_i;
          probe_d.v1_age = age_seen;
        end
        if (age_seen > probe_i.v2_age) begin
          probe_d.v2_v   = 1'b1;
          probe_d.v2_idx = cell_idx_i;
          probe_d.v2_age = age_seen;
        end
      end
    end else if (rel_match) begin
      probe_d.rel_uses = uses_q;
      probe_d.rel_len  = len_q;
      probe_d.rel_page = page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= 1'b0;
      valid_q <= 1'b0;
      tag_q   <= '0;
      page_q  <= '0;
      len_q   <= '0;
      age_q   <= '0;
      uses_q  <= '0;
    end else begin
      pv_q <= pv_i;
      if (pv_i && !probe_i.rel_op && !match) begin
        age_q <= age_inc;
      end
      if (sel) begin
        case (cmd_i.op)
          CMD_HIT: begin
            age_q <= '0;
            if (uses_q != USE_MAX) begin
              uses_q <= uses_q + use_t'(1);
            end
          end
          CMD_FILL: begin
            valid_q <= 1'b1;
            tag_q   <= cmd_i.hash;
            page_q  <= cmd_i.page;
            len_q   <= cmd_i.len;
            age_q   <= '0;
            uses_q  <= use_t'(1);
          end
          CMD_REL: begin
            uses_q <= uses_q - use_t'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pv_i) begin
      probe_q <= probe_d;
    end
  end

  assign pv_o    = pv_q;
  assign probe_o = probe_q;
  assign busy_o  = (uses_q != '0);

endmodule

// ===== hdl/page_cache_lru_refcount_core.sv =====
`timescale 1ns / 1ps
// Fully associative page-slot cache with LRU replacement and per-entry use counts.
// Input channel in_valid_i/in_stall_o carries a request (look up or fill a page)
// or a release (drop one use of an entry). Output channel out_valid_o/out_stall_i
// returns exactly one result per accepted item.
// Each entry lives in one cell of a row of ENTRIES cells. An accepted item becomes
// a token that walks the row one cell per cycle; every cell ages itself, compares
// its tag and updates the token's hit, empty and victim candidates. At the row's
// end the controller picks the outcome and sends at most one update to the chosen cell.
// A bad request skips the row and goes straight to the holding register. One item
// is in work at a time: the input stalls from the transfer of an item until its
// result moves on into the output register.
// A new item is taken while a finished result still waits in the output register;
// when the receiver stalls, the next result waits in a holding register and the
// input stalls until the output register frees up.
// Reset clears every entry, the use counts, the full flag and both channels.
module page_cache_lru_refcount_core import pclrc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_e;

  state_e  state_q, state_d;
  logic    accept, out_free;
  logic    full_q, full_d;
  logic    inj_v_q;
  probe_t  inj_q, inj_d;
  commit_t cmd_q, cmd_d;
  rsp_t    pend_q, pend_d, out_q;
  logic    out_valid_q;
  logic [LEN_W-1:0] cnt_q;

  logic   pv_w    [ENTRIES+1];
  probe_t probe_w [ENTRIES+1];
  logic [ENTRIES-1:0] busy_w, pv_vec;

  assign pv_w[0]    = inj_v_q;
  assign probe_w[0] = inj_q;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pclrc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (idx_t'(g)),
      .pv_i       (pv_w[g]),
      .probe_i    (probe_w[g]),
      .cmd_i      (cmd_q),
      .pv_o       (pv_w[g+1]),
      .probe_o    (probe_w[g+1]),
      .busy_o     (busy_w[g])
    );
    assign pv_vec[g] = pv_w[g+1];
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Request front end: page number, range checks and byte count.
  logic [OFF_W-1:0] page_full, left;
  logic             bad_req;
  logic [LEN_W-1:0] cnt_d;

  assign page_full = in_data_i.byte_offset >> VIEW_LOG2;
  assign bad_req   = (in_data_i.file_hash == '0)
                  || (in_data_i.byte_offset > in_data_i.file_size)
                  || ((page_full >> PAGE_W) != '0);
  assign left      = in_data_i.file_size - in_data_i.byte_offset;
  assign cnt_d     = (left >= VIEW_BYTES) ? LEN_W'(VIEW_BYTES) : LEN_W'(left);

  always_comb begin
    inj_d        = '0;
    inj_d.rel_op = in_data_i.action;
    inj_d.hash   = in_data_i.file_hash;
    inj_d.page   = PAGE_W'(page_full);
    inj_d.rel    = in_data_i.release_slot;
  end

  // Outcome of a finished walk.
  probe_t p;
  idx_t   pick;
  logic [ENTRIES-1:0] busy_after;

  assign p = probe_w[ENTRIES];

  always_comb begin
    state_d    = state_q;
    full_d     = full_q;
    cmd_d      = '0;
    pend_d     = pend_q;
    pick       = '0;
    busy_after = busy_w;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!in_data_i.action && bad_req) begin
            pend_d          = '0;
            pend_d.status   = ST_BAD_REQ;
            pend_d.all_busy = full_q;
            state_d         = S_HOLD;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (p.rel_op) begin
          pend_d            = '0;
          pend_d.slot_index = p.rel;
          if (pv_w[ENTRIES]) begin
            if (p.rel_uses == '0) begin
              pend_d.status = ST_REL_UNDER;
            end else begin
              pend_d.status     = ST_RELEASED;
              pend_d.byte_count = p.rel_len;
              pend_d.page_index = p.rel_page;
              cmd_d.v           = 1'b1;
              cmd_d.op          = CMD_REL;
              cmd_d.idx         = idx_t'(p.rel);
              if (p.rel_uses == use_t'(1)) begin
                full_d = 1'b0;
              end
            end
          end
        end else begin
          pend_d            = '0;
          pend_d.page_index = p.page;
          cmd_d.hash        = p.hash;
          cmd_d.page        = p.page;
          cmd_d.len         = cnt_q;
          if (p.hit_v) begin
            pend_d.status     = ST_HIT;
            pick              = p.hit_idx;
            pend_d.byte_count = p.hit_len;
            cmd_d.v           = 1'b1;
            cmd_d.op          = CMD_HIT;
          end else if (p.empty_v) begin
            pend_d.status     = ST_FILLED;
            pick              = p.empty_idx;
            pend_d.byte_count = cnt_q;
            cmd_d.v           = 1'b1;
            cmd_d.op          = CMD_FILL;
          end else if (!p.some_free) begin
            pend_d.status = ST_ALL_BUSY;
            full_d        = 1'b1;
          end else if (p.v1_v || p.v2_v) begin
            pend_d.status     = ST_EVICTED;
            pick              = p.v1_v ? p.v1_idx : p.v2_idx;
            pend_d.byte_count = cnt_q;
            cmd_d.v           = 1'b1;
            cmd_d.op          = CMD_FILL;
          end else begin
            pend_d.status = ST_NO_VICTIM;
          end
          pend_d.slot_index = SLOT_W'(pick);
          cmd_d.idx         = pick;
          busy_after[pick]  = 1'b1;
          if (cmd_d.v && (&busy_after)) begin
            full_d = 1'b1;
          end
          cmd_d.v = cmd_d.v && pv_w[ENTRIES];
        end
        if (pv_w[ENTRIES]) begin
          state_d = S_HOLD;
        end else begin
          full_d = full_q;
          pend_d = pend_q;
        end
        pend_d.all_busy = full_d;
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      full_q      <= 1'b0;
      inj_v_q     <= 1'b0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
      inj_v_q <= accept && !(!in_data_i.action && bad_req);
      cmd_q   <= cmd_d;
      if (state_q == S_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (accept) begin
      inj_q <= inj_d;
      cnt_q <= cnt_d;
    end
    if (state_q == S_HOLD && out_free) begin
      out_q <= pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({pv_vec, inj_v_q}) <= 1)
    else $error("more than one token in the cell row");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_w[ENTRIES] |-> state_q == S_WALK)
    else $error("token left the row outside of a walk");

  a_cmd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.v |-> state_q == S_HOLD)
    else $error("entry update outside of the hold state");

  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_q) |-> $past(pv_w[ENTRIES]))
    else $error("full flag set without a finished walk");

endmodule

// ===== test/page_cache_lru_refcount_core_test.sv =====
`timescale 1ns / 1ps

module page_cache_lru_refcount_core_test;
  import pclrc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  page_cache_lru_refcount_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the cache contents.
  logic                  ent_valid [ENTRIES];
  logic [HASH_W-1:0]     ent_tag   [ENTRIES];
  logic [PAGE_W-1:0]     ent_page  [ENTRIES];
  logic [LEN_W-1:0]      ent_len   [ENTRIES];
  logic [AGE_BITS-1:0]   ent_age   [ENTRIES];
  logic [USE_BITS-1:0]   ent_uses  [ENTRIES];
  logic                  busy_flag;

  rsp_t pending_rsp[$];
  int   error_count = 0;
  int   cycle_count = 0;
  logic stall_enable = 1'b1;
  logic [HASH_W-1:0] hot_hash[4];

  function automatic bit every_entry_busy();
    for (int i = 0; i < ENTRIES; i++) if (ent_uses[i] == '0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void bump_use(int i);
    if (ent_uses[i] != USE_MAX) ent_uses[i]++;
    if (every_entry_busy()) busy_flag = 1'b1;
  endfunction

  function automatic rsp_t make_rsp(status_e st, int idx, logic [LEN_W-1:0] cnt,
                                    logic [PAGE_W-1:0] pg);
    rsp_t r;
    r.status = st;
    r.slot_index = SLOT_W'(idx);
    r.byte_count = cnt;
    r.page_index = pg;
    r.all_busy = busy_flag;
    return r;
  endfunction

  function automatic rsp_t predict_cache(req_t q);
    logic [OFF_W-1:0] pg40, left, cnt;
    logic [PAGE_W-1:0] pg;
    int hit, pick;
    logic [AGE_BITS-1:0] older;
    status_e st;
    hit = -1;
    pick = -1;
    if (q.action) begin
      if (q.release_slot >= ENTRIES || ent_uses[q.release_slot] == '0)
        return make_rsp(ST_REL_UNDER, q.release_slot, '0, '0);
      ent_uses[q.release_slot]--;
      if (ent_uses[q.release_slot] == '0) busy_flag = 1'b0;
      return make_rsp(ST_RELEASED, q.release_slot, ent_len[q.release_slot],
                      ent_page[q.release_slot]);
    end
    pg40 = q.byte_offset >> VIEW_LOG2;
    if (q.file_hash == '0 || q.byte_offset > q.file_size || pg40 > 40'hFFFFFF)
      return make_rsp(ST_BAD_REQ, 0, '0, '0);
    pg = pg40[PAGE_W-1:0];
    for (int i = 0; i < ENTRIES; i++) begin
      if (ent_valid[i] && ent_tag[i] == q.file_hash && ent_page[i] == pg) hit = i;
      else if (ent_age[i] != AGE_MAX) ent_age[i]++;
    end
    if (hit >= 0) begin
      ent_age[hit] = '0;
      bump_use(hit);
      return make_rsp(ST_HIT, hit, ent_len[hit], pg);
    end
    for (int i = 0; i < ENTRIES && pick < 0; i++) if (!ent_valid[i]) pick = i;
    if (pick >= 0) st = ST_FILLED;
    else begin
      if (every_entry_busy()) begin
        busy_flag = 1'b1;
        return make_rsp(ST_ALL_BUSY, 0, '0, pg);
      end
      older = '0;
      for (int i = 0; i < ENTRIES; i++)
        if (ent_tag[i] != q.file_hash && ent_uses[i] == '0 && ent_age[i] > older) begin
          older = ent_age[i];
          pick = i;
        end
      if (pick < 0)
        for (int i = 0; i < ENTRIES; i++)
          if (ent_uses[i] == '0 && ent_age[i] > older) begin
            older = ent_age[i];
            pick = i;
          end
      if (pick < 0) return make_rsp(ST_NO_VICTIM, 0, '0, pg);
      st = ST_EVICTED;
    end
    left = q.file_size - q.byte_offset;
    cnt = (left >= VIEW_BYTES) ? VIEW_BYTES : left;
    ent_valid[pick] = 1'b1;
    ent_tag[pick] = q.file_hash;
    ent_page[pick] = pg;
    ent_len[pick] = cnt[LEN_W-1:0];
    ent_age[pick] = '0;
    ent_uses[pick] = '0;
    bump_use(pick);
    return make_rsp(st, pick, ent_len[pick], pg);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int gap_length();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // One transfer on the input channel, followed by a random gap when idle is set.
  task automatic send_item(req_t q, bit idle = 1'b1);
    int gap;
    in_data_i <= q;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rsp.push_back(predict_cache(q));
    gap = idle ? gap_length() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rsp.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (out_data_o.status !== e.status)
          report_mismatch("status", out_data_o.status, e.status);
        if (out_data_o.slot_index !== e.slot_index)
          report_mismatch("slot_index", out_data_o.slot_index, e.slot_index);
        if (out_data_o.byte_count !== e.byte_count)
          report_mismatch("byte_count", out_data_o.byte_count, e.byte_count);
        if (out_data_o.page_index !== e.page_index)
          report_mismatch("page_index", out_data_o.page_index, e.page_index);
        if (out_data_o.all_busy !== e.all_busy)
          report_mismatch("all_busy", out_data_o.all_busy, e.all_busy);
      end
    end
    if (!stall_enable) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_stall_i <= 1'b1;
    else if (out_stall_i && $urandom_range(0, 2) == 0) out_stall_i <= 1'b0;
    else if (!out_stall_i) out_stall_i <= ($urandom_range(0, 5) == 0);
  end

  function automatic req_t make_request(logic [HASH_W-1:0] h, logic [OFF_W-1:0] off,
                                        logic [OFF_W-1:0] size);
    req_t q;
    q = '0;
    q.action = 1'b0;
    q.file_hash = h;
    q.byte_offset = off;
    q.file_size = size;
    q.release_slot = SLOT_W'($urandom);
    return q;
  endfunction

  function automatic req_t make_release(int s);
    req_t q;
    q = req_t'({$urandom, $urandom, $urandom, $urandom});
    q.action = 1'b1;
    q.release_slot = SLOT_W'(s);
    return q;
  endfunction

  // The sender goes idle first so that no transfer repeats while waiting.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_special_cases();
    send_item(make_request('0, 40'd5, 40'd100));
    send_item(make_request(32'h1, 40'd200, 40'd100));
    send_item(make_request(32'h1, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF));
    send_item(make_request(32'h1, 40'd0, 40'd0));
    send_item(make_request(32'hFFFF_FFFF, 40'hFF_FFFF_0000, 40'hFF_FFFF_FFFF));
    send_item(make_request(32'hFFFF_FFFF, 40'h00_FFFF_FFFF, 40'h01_0000_0000));
    send_item(make_request(32'h1, 40'd0, 40'd0));
    send_item(make_release(0));
    send_item(make_release(0));
    send_item(make_release(15));
  endtask

  // Fill every entry with uses held, then hit the all-in-use and eviction paths.
  task automatic test_full_cache();
    for (int i = 0; i < ENTRIES; i++)
      send_item(make_request(32'h100 + i, 40'd0, 40'd70000));
    send_item(make_request(32'h999, 40'd0, 40'd10));
    for (int i = 0; i < ENTRIES; i++) send_item(make_release(i));
    send_item(make_request(32'h999, 40'd65536, 40'd70000));
    send_item(make_request(32'h100, 40'd0, 40'd70000));
  endtask

  task automatic test_random_traffic();
    req_t q;
    int kind;
    for (int n = 0; n < 1920; n++) begin
      if (n == 900) begin
        // Let the output side run dry before carrying on.
        wait_drained();
        stall_enable = 1'b0;
      end
      if (n == 1200) stall_enable = 1'b1;
      if (n % 300 == 0) for (int k = 0; k < 4; k++) hot_hash[k] = $urandom | 1;
      kind = $urandom_range(0, 19);
      if (kind < 11) begin
        logic [OFF_W-1:0] off;
        off = OFF_W'($urandom_range(0, 40)) << VIEW_LOG2 | OFF_W'($urandom_range(0, 65535));
        q = make_request(hot_hash[$urandom_range(0, 3)], off,
                         off + OFF_W'($urandom_range(0, 200000)));
      end else if (kind < 17) q = make_release($urandom_range(0, ENTRIES - 1));
      else if (kind < 18) q = make_request(HASH_W'($urandom_range(0, 1)),
                                           OFF_W'($urandom_range(0, 9)),
                                           OFF_W'($urandom_range(0, 9)));
      else begin
        q = req_t'({$urandom, $urandom, $urandom, $urandom});
        q.action = 1'b0;
        if ($urandom_range(0, 1)) q.byte_offset[OFF_W-1 -: 8] = '0;
      end
      send_item(q, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      ent_valid[i] = 1'b0;
      ent_tag[i] = '0;
      ent_page[i] = '0;
      ent_len[i] = '0;
      ent_age[i] = '0;
      ent_uses[i] = '0;
    end
    busy_flag = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_full_cache();
    test_random_traffic();
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pclrc_pkg.sv
hdl/pclrc_cell.sv
hdl/page_cache_lru_refcount_core.sv
test/page_cache_lru_refcount_core_test.sv
